// File: rtl/flvtp_pkg.sv
package flvtp_pkg;

    localparam logic [2:0] PH_FILE  = 3'd0;
    localparam logic [2:0] PH_PREV  = 3'd1;
    localparam logic [2:0] PH_TAG   = 3'd2;
    localparam logic [2:0] PH_FIRST = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_AUDIO  = 3'd1;
    localparam logic [2:0] KIND_VIDEO  = 3'd2;
    localparam logic [2:0] KIND_SCRIPT = 3'd3;
    localparam logic [2:0] KIND_OTHER  = 3'd4;

    localparam logic [7:0] TAG_AUDIO  = 8'd8;
    localparam logic [7:0] TAG_VIDEO  = 8'd9;
    localparam logic [7:0] TAG_SCRIPT = 8'd18;

    // Byte positions inside the file header and the tag header.
    localparam logic [23:0] FH_VERSION_POS = 24'd3;
    localparam logic [23:0] FH_FLAGS_POS   = 24'd4;
    localparam logic [23:0] FH_OFFSET_POS  = 24'd5;
    localparam logic [23:0] FH_LAST_POS    = 24'd8;
    localparam logic [23:0] PREV_LAST_POS  = 24'd3;
    localparam logic [23:0] TH_SIZE_LAST   = 24'd3;
    localparam logic [23:0] TH_TIME_LAST   = 24'd6;
    localparam logic [23:0] TH_LAST_POS    = 24'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_file;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] data_size;
        logic [23:0] timestamp;
        logic [7:0]  version;
        logic [7:0]  flags;
        logic [31:0] header_size;
        logic [3:0]  sound_format;
        logic [1:0]  sound_rate;
        logic        sound_size;
        logic        stereo;
        logic [3:0]  frame_type;
        logic [3:0]  codec_id;
    } result_t;

    function automatic logic [2:0] kind_of(input logic [7:0] tag_type);
        logic [2:0] k;
        begin
            if (tag_type == TAG_AUDIO)
            begin
                k = KIND_AUDIO;
            end
            else if (tag_type == TAG_VIDEO)
            begin
                k = KIND_VIDEO;
            end
            else if (tag_type == TAG_SCRIPT)
            begin
                k = KIND_SCRIPT;
            end
            else
            begin
                k = KIND_OTHER;
            end
            return k;
        end
    endfunction

endpackage

// File: rtl/flvtp_in_stage.sv
module flvtp_in_stage
    import flvtp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  take
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: rtl/flvtp_core.sv
module flvtp_core
    import flvtp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    logic [2:0]  phase_reg, phase_next;
    logic [23:0] count_reg, count_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] offset_reg, offset_next;
    logic [7:0]  tag_type_reg, tag_type_next;
    logic [23:0] size_reg, size_next;
    logic [23:0] time_reg, time_next;

    logic [2:0]  ph;
    logic [23:0] cnt;
    logic [7:0]  ver;
    logic [7:0]  flg;
    logic [31:0] off;
    logic [7:0]  ttype;
    logic [23:0] dsize;
    logic [23:0] tstamp;
    logic [7:0]  b;
    logic        is_av;
    logic [23:0] size_less;

    always_comb
    begin
        b      = item.data_byte;
        ph     = phase_reg;
        cnt    = count_reg;
        ver    = version_reg;
        flg    = flags_reg;
        off    = offset_reg;
        ttype  = tag_type_reg;
        dsize  = size_reg;
        tstamp = time_reg;
        // A new file restarts parsing with this byte as header byte zero.
        if (item.new_file)
        begin
            ph     = PH_FILE;
            cnt    = '0;
            ver    = '0;
            flg    = '0;
            off    = '0;
            ttype  = '0;
            dsize  = '0;
            tstamp = '0;
        end
        if (ph > PH_SKIP)
        begin
            ph  = PH_FILE;
            cnt = '0;
        end

        is_av     = (ttype == TAG_AUDIO) || (ttype == TAG_VIDEO);
        size_less = dsize - 24'd1;

        phase_next    = ph;
        count_next    = cnt;
        version_next  = ver;
        flags_next    = flg;
        offset_next   = off;
        tag_type_next = ttype;
        size_next     = dsize;
        time_next     = tstamp;
        res_valid     = 1'b0;
        res           = '0;

        unique case (ph)
            PH_FILE:
            begin
                if (cnt == FH_VERSION_POS)
                begin
                    version_next = b;
                end
                else if (cnt == FH_FLAGS_POS)
                begin
                    flags_next = b;
                end
                else if (cnt >= FH_OFFSET_POS)
                begin
                    offset_next = {off[23:0], b};
                end
                if (cnt >= FH_LAST_POS)
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_HEADER;
                    res.version     = ver;
                    res.flags       = flg;
                    res.header_size = offset_next;
                    phase_next      = PH_PREV;
                    count_next      = '0;
                end
                else
                begin
                    count_next = cnt + 24'd1;
                end
            end
            PH_PREV:
            begin
                if (cnt >= PREV_LAST_POS)
                begin
                    phase_next = PH_TAG;
                    count_next = '0;
                end
                else
                begin
                    count_next = cnt + 24'd1;
                end
            end
            PH_TAG:
            begin
                if (cnt == 24'd0)
                begin
                    tag_type_next = b;
                end
                else if (cnt <= TH_SIZE_LAST)
                begin
                    size_next = {dsize[15:0], b};
                end
                else if (cnt <= TH_TIME_LAST)
                begin
                    time_next = {tstamp[15:0], b};
                end
                if (cnt < TH_LAST_POS)
                begin
                    count_next = cnt + 24'd1;
                end
                else if (is_av && (dsize != 24'd0))
                begin
                    phase_next = PH_FIRST;
                    count_next = '0;
                end
                else
                begin
                    // Empty audio or video tags and all other tags report here.
                    res_valid     = 1'b1;
                    res.kind      = kind_of(ttype);
                    res.data_size = dsize;
                    res.timestamp = tstamp;
                    if ((dsize == 24'd0) || is_av)
                    begin
                        phase_next = PH_PREV;
                        count_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                        count_next = dsize;
                    end
                end
            end
            PH_FIRST:
            begin
                res_valid     = 1'b1;
                res.kind      = kind_of(ttype);
                res.data_size = dsize;
                res.timestamp = tstamp;
                if (ttype == TAG_AUDIO)
                begin
                    res.sound_format = b[7:4];
                    res.sound_rate   = b[3:2];
                    res.sound_size   = b[1];
                    res.stereo       = b[0];
                end
                else
                begin
                    res.frame_type = b[7:4];
                    res.codec_id   = b[3:0];
                end
                count_next = size_less;
                phase_next = (size_less == 24'd0) ? PH_PREV : PH_SKIP;
            end
            default:
            begin
                if (cnt <= 24'd1)
                begin
                    phase_next = PH_PREV;
                    count_next = '0;
                end
                else
                begin
                    count_next = cnt - 24'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FILE;
            count_reg    <= '0;
            version_reg  <= '0;
            flags_reg    <= '0;
            offset_reg   <= '0;
            tag_type_reg <= '0;
            size_reg     <= '0;
            time_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            version_reg  <= version_next;
            flags_reg    <= flags_next;
            offset_reg   <= offset_next;
            tag_type_reg <= tag_type_next;
            size_reg     <= size_next;
            time_reg     <= time_next;
        end
    end

endmodule

// File: rtl/flvtp_out_stage.sv
module flvtp_out_stage
    import flvtp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// File: rtl/flv_tag_header_parser.sv
// FLV tag header parser. Takes an FLV file one byte per word on the input
// channel and gives one word on the output channel for the 9-byte file header
// and for each tag. The throughput is one byte per clock, limited only by the
// output side: a byte is registered in the input register, parsed by the header
// state logic when it leaves that register, and its result lands in the output
// register. Headers report with their last byte; audio and video tags with a
// payload report with the first payload byte. Setting new_file on a byte
// restarts parsing with that byte as header byte 0.
module flv_tag_header_parser
    import flvtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        new_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [23:0] data_size,
    output logic [23:0] timestamp,
    output logic [7:0]  version,
    output logic [7:0]  flags,
    output logic [31:0] header_size,
    output logic [3:0]  sound_format,
    output logic [1:0]  sound_rate,
    output logic        sound_size,
    output logic        stereo,
    output logic [3:0]  frame_type,
    output logic [3:0]  codec_id
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    can_load;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.data_byte = data_byte;
    assign in_item.new_file  = new_file;

    // A byte leaves the input register only when its result has a place to go.
    assign take = item_valid && can_load;

    flvtp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    flvtp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    flvtp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign data_size    = out_res.data_size;
    assign timestamp    = out_res.timestamp;
    assign version      = out_res.version;
    assign flags        = out_res.flags;
    assign header_size  = out_res.header_size;
    assign sound_format = out_res.sound_format;
    assign sound_rate   = out_res.sound_rate;
    assign sound_size   = out_res.sound_size;
    assign stereo       = out_res.stereo;
    assign frame_type   = out_res.frame_type;
    assign codec_id     = out_res.codec_id;

    // A byte held in the input register is never dropped while the output is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !can_load) |=> item_valid && $stable(item))
        else $error("input word lost while output stalled");

    // Tag results never carry file header fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_HEADER) |->
            (version == 8'd0 && flags == 8'd0 && header_size == 32'd0))
        else $error("header fields set in a tag word");

    // Audio fields belong to audio words only.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_AUDIO) |->
            (sound_format == 4'd0 && sound_rate == 2'd0 && !sound_size && !stereo))
        else $error("audio fields set in a non-audio word");

    // Video fields belong to video words only.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_VIDEO) |-> (frame_type == 4'd0 && codec_id == 4'd0))
        else $error("video fields set in a non-video word");

endmodule
